// File: hdl/crb_pkg.sv
package crb_pkg;

	// Default screen geometry.
	localparam int CRB_SCREEN_WIDTH  = 800;
	localparam int CRB_SCREEN_HEIGHT = 480;

	// A bitmap pixel is drawn only when its alpha is above this level.
	localparam logic [7:0] CRB_ALPHA_LIMIT = 8'd128;

	// Function codes of an input word.
	localparam logic [2:0] FUNC_FILL    = 3'd0;
	localparam logic [2:0] FUNC_RESTORE = 3'd1;
	localparam logic [2:0] FUNC_SAVE    = 3'd2;
	localparam logic [2:0] FUNC_OPEN    = 3'd3;
	localparam logic [2:0] FUNC_PIXEL   = 3'd4;
	localparam logic [2:0] FUNC_READ    = 3'd5;

	// Status codes of a result word.
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_OFFSCREEN = 2'd1;
	localparam logic [1:0] STATUS_NO_SPACE  = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic decode;
		logic mul;
		logic step;
		logic wr_pix;
		logic rd;
		logic out_load;
	} crb_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_rect;
		logic is_pix;
		logic is_read;
		logic skip;
		logic last;
	} crb_stat_t;

endpackage

// File: hdl/crb_if.sv
// Input channel: one command word per handshake.
interface crb_in_if;
	logic               valid;
	logic               ready;
	logic [2:0]         func;
	logic signed [11:0] pos_x;
	logic signed [11:0] pos_y;
	logic [10:0]        rect_width;
	logic [10:0]        rect_height;
	logic [31:0]        fill_color;
	logic [31:0]        source_pixel;

	modport source (output valid, func, pos_x, pos_y, rect_width, rect_height,
		fill_color, source_pixel, input ready);
	modport sink (input valid, func, pos_x, pos_y, rect_width, rect_height,
		fill_color, source_pixel, output ready);
endinterface

// Output channel: one result word per handshake.
interface crb_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] read_value;
	logic [18:0] pixels_written;
	logic [1:0]  status;

	modport source (output valid, read_value, pixels_written, status, input ready);
	modport sink (input valid, read_value, pixels_written, status, output ready);
endinterface

// File: hdl/crb_ctrl.sv
module crb_ctrl
	import crb_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  crb_stat_t stat,
	output crb_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DECODE = 3'd1;
	localparam logic [2:0] S_MUL    = 3'd2;
	localparam logic [2:0] S_LOOP   = 3'd3;
	localparam logic [2:0] S_DRAIN  = 3'd4;
	localparam logic [2:0] S_WRPIX  = 3'd5;
	localparam logic [2:0] S_RDREQ  = 3'd6;
	localparam logic [2:0] S_RESULT = 3'd7;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.decode = 1'b1;
				if (stat.is_rect || stat.is_pix || stat.is_read) begin
					state_d = S_MUL;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				if (stat.skip) begin
					state_d = S_RESULT;
				end else if (stat.is_rect) begin
					state_d = S_LOOP;
				end else if (stat.is_pix) begin
					state_d = S_WRPIX;
				end else begin
					state_d = S_RDREQ;
				end
			end
			S_LOOP: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_RESULT;
			end
			S_WRPIX: begin
				cmd.wr_pix = 1'b1;
				state_d    = S_RESULT;
			end
			S_RDREQ: begin
				cmd.rd  = 1'b1;
				state_d = S_RESULT;
			end
			S_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

endmodule

// File: hdl/crb_datapath.sv
module crb_datapath
	import crb_pkg::*;
#(
	parameter int SCREEN_WIDTH  = CRB_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = CRB_SCREEN_HEIGHT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  crb_cmd_t           cmd,
	output crb_stat_t          stat,
	input  logic [2:0]         func,
	input  logic signed [11:0] pos_x,
	input  logic signed [11:0] pos_y,
	input  logic [10:0]        rect_width,
	input  logic [10:0]        rect_height,
	input  logic [31:0]        fill_color,
	input  logic [31:0]        source_pixel,
	output logic [31:0]        read_value,
	output logic [18:0]        pixels_written,
	output logic [1:0]         status
);

	localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic signed [12:0] SW13 = 13'(SCREEN_WIDTH);
	localparam logic signed [12:0] SH13 = 13'(SCREEN_HEIGHT);
	localparam logic [21:0] SW22 = 22'(SCREEN_WIDTH);
	localparam logic [ADDR_W-1:0] SW_A = ADDR_W'(SCREEN_WIDTH);

	// Latched input word.
	logic [2:0]         func_q;
	logic signed [11:0] pos_x_q;
	logic signed [11:0] pos_y_q;
	logic [10:0]        w_q;
	logic [10:0]        h_q;
	logic [31:0]        color_q;
	logic [31:0]        pix_q;

	// Bitmap state.
	logic signed [11:0] bm_left_q;
	logic signed [11:0] bm_top_q;
	logic [10:0]        bm_width_q;
	logic [10:0]        bm_height_q;
	logic [10:0]        bm_col_q;
	logic [10:0]        bm_row_q;
	logic               bm_open_q;

	// Decoded operation.
	logic [10:0] x0_q;
	logic [10:0] y0_q;
	logic [10:0] x1m_q;
	logic [10:0] y1m_q;
	logic        skip_q;
	logic [1:0]  status_q;

	// Scan counters and write stage.
	logic [10:0]       col_q;
	logic [10:0]       row_q;
	logic [ADDR_W-1:0] row_base_q;
	logic [18:0]       cnt_q;
	logic              wr_v_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	// Stores and their read registers.
	logic [31:0] frame_mem [0:DEPTH-1];
	logic [31:0] back_mem  [0:DEPTH-1];
	logic [31:0] fr_rd_q;
	logic [31:0] bg_rd_q;

	// Output word.
	logic [31:0] out_value_q;
	logic [18:0] out_written_q;
	logic [1:0]  out_status_q;

	logic              is_rect;
	logic              is_pix;
	logic              is_read;
	logic [ADDR_W-1:0] cur_addr;
	logic [21:0]       prod;
	logic              rd_en;
	logic              fr_we;
	logic              bg_we;
	logic [31:0]       fr_wdata;

	// Decode results.
	logic signed [12:0] xs, ys, xe, ye, x0c, y0c, x1c, y1c;
	logic               space;
	logic [10:0]        rows_left;
	logic signed [12:0] sx, sy;
	logic               draw;
	logic               read_on;
	logic [11:0]        ncol, nrow;
	logic [10:0]        dec_x0, dec_y0, dec_x1m, dec_y1m;
	logic               dec_skip;
	logic [1:0]         dec_status;

	assign is_rect = (func_q == FUNC_FILL) || (func_q == FUNC_RESTORE) ||
		(func_q == FUNC_SAVE);
	assign is_pix  = (func_q == FUNC_PIXEL);
	assign is_read = (func_q == FUNC_READ);

	assign stat.is_rect = is_rect;
	assign stat.is_pix  = is_pix;
	assign stat.is_read = is_read;
	assign stat.skip    = skip_q;
	assign stat.last    = (col_q == x1m_q) && (row_q == y1m_q);

	// Rectangle clipping and bitmap pixel placement.
	always_comb begin
		xs  = 13'(pos_x_q);
		ys  = 13'(pos_y_q);
		xe  = xs + 13'({2'b00, w_q});
		ye  = ys + 13'({2'b00, h_q});
		x0c = (xs < 0) ? 13'sd0 : xs;
		y0c = (ys < 0) ? 13'sd0 : ys;
		x1c = (xe > SW13) ? SW13 : xe;
		y1c = (ye > SH13) ? SH13 : ye;

		space = bm_open_q && (bm_width_q != '0) && (bm_height_q != '0) &&
			(bm_row_q < bm_height_q);
		rows_left = bm_height_q - 11'd1 - bm_row_q;
		sx = 13'(bm_left_q) + 13'({2'b00, bm_col_q});
		sy = 13'(bm_top_q) + 13'({2'b00, rows_left});
		draw = (sx >= 0) && (sx < SW13) && (sy >= 0) && (sy < SH13) &&
			(pix_q[31:24] > CRB_ALPHA_LIMIT);
		read_on = (xs >= 0) && (xs < SW13) && (ys >= 0) && (ys < SH13);

		ncol = {1'b0, bm_col_q} + 12'd1;
		nrow = {1'b0, bm_row_q} + 12'd1;
	end

	// Scan bounds, skip flag and status of the latched word.
	always_comb begin
		dec_status = STATUS_OK;
		dec_skip   = 1'b1;
		dec_x0     = x0c[10:0];
		dec_y0     = y0c[10:0];
		dec_x1m    = 11'(x1c - 13'sd1);
		dec_y1m    = 11'(y1c - 13'sd1);
		unique case (func_q) inside
			FUNC_FILL, FUNC_RESTORE, FUNC_SAVE: begin
				dec_skip = (x1c <= x0c) || (y1c <= y0c);
			end
			FUNC_PIXEL: begin
				dec_x0  = sx[10:0];
				dec_y0  = sy[10:0];
				dec_x1m = sx[10:0];
				dec_y1m = sy[10:0];
				if (!space) begin
					dec_status = STATUS_NO_SPACE;
				end else begin
					dec_skip = !draw;
				end
			end
			FUNC_READ: begin
				dec_x0  = xs[10:0];
				dec_y0  = ys[10:0];
				dec_x1m = xs[10:0];
				dec_y1m = ys[10:0];
				if (read_on) begin
					dec_skip = 1'b0;
				end else begin
					dec_status = STATUS_OFFSCREEN;
				end
			end
			default: begin
				dec_skip = 1'b1;
			end
		endcase
	end

	// Scan address and store port controls.
	assign prod     = {11'd0, y0_q} * SW22;
	assign cur_addr = row_base_q + ADDR_W'(col_q);
	assign rd_en    = cmd.step || cmd.rd;
	assign fr_we    = wr_v_s1 && (func_q != FUNC_SAVE);
	assign bg_we    = wr_v_s1 && (func_q == FUNC_SAVE);

	always_comb begin
		case (func_q)
			FUNC_FILL:  fr_wdata = color_q;
			FUNC_PIXEL: fr_wdata = pix_q;
			default:    fr_wdata = bg_rd_q;
		endcase
	end

	// Input latch, decode, scan and output registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			pos_x_q <= pos_x;
			pos_y_q <= pos_y;
			w_q     <= rect_width;
			h_q     <= rect_height;
			color_q <= fill_color;
			pix_q   <= source_pixel;
			cnt_q   <= '0;
		end
		if (cmd.decode) begin
			status_q <= dec_status;
			skip_q   <= dec_skip;
			x0_q     <= dec_x0;
			y0_q     <= dec_y0;
			x1m_q    <= dec_x1m;
			y1m_q    <= dec_y1m;
		end
		if (cmd.mul) begin
			row_base_q <= ADDR_W'(prod);
			col_q      <= x0_q;
			row_q      <= y0_q;
		end
		if (cmd.step) begin
			cnt_q <= cnt_q + 19'd1;
			if (col_q == x1m_q) begin
				col_q      <= x0_q;
				row_q      <= row_q + 11'd1;
				row_base_q <= row_base_q + SW_A;
			end else begin
				col_q <= col_q + 11'd1;
			end
		end
		if (cmd.wr_pix) begin
			cnt_q <= 19'd1;
		end
		wr_addr_s1 <= cur_addr;
		if (cmd.out_load) begin
			out_value_q   <= (is_read && !skip_q) ? fr_rd_q : 32'd0;
			out_written_q <= cnt_q;
			out_status_q  <= status_q;
		end
	end

	// Control state: bitmap cursor and write stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bm_left_q   <= '0;
			bm_top_q    <= '0;
			bm_width_q  <= '0;
			bm_height_q <= '0;
			bm_col_q    <= '0;
			bm_row_q    <= '0;
			bm_open_q   <= 1'b0;
			wr_v_s1     <= 1'b0;
		end else begin
			wr_v_s1 <= cmd.step || cmd.wr_pix;
			if (cmd.decode && (func_q == FUNC_OPEN)) begin
				bm_left_q   <= pos_x_q;
				bm_top_q    <= pos_y_q;
				bm_width_q  <= w_q;
				bm_height_q <= h_q;
				bm_col_q    <= '0;
				bm_row_q    <= '0;
				bm_open_q   <= 1'b1;
			end else if (cmd.decode && is_pix && space) begin
				if (ncol >= {1'b0, bm_width_q}) begin
					bm_col_q <= '0;
					if (nrow >= {1'b0, bm_height_q}) begin
						bm_row_q  <= '0;
						bm_open_q <= 1'b0;
					end else begin
						bm_row_q <= nrow[10:0];
					end
				end else begin
					bm_col_q <= ncol[10:0];
				end
			end
		end
	end

	// Screen store.
	always_ff @(posedge clk) begin
		if (fr_we) begin
			frame_mem[wr_addr_s1] <= fr_wdata;
		end
		if (rd_en) begin
			fr_rd_q <= frame_mem[cur_addr];
		end
	end

	// Background store.
	always_ff @(posedge clk) begin
		if (bg_we) begin
			back_mem[wr_addr_s1] <= fr_rd_q;
		end
		if (rd_en) begin
			bg_rd_q <= back_mem[cur_addr];
		end
	end

	assign read_value     = out_value_q;
	assign pixels_written = out_written_q;
	assign status         = out_status_q;

endmodule

// File: hdl/clipped_rect_blitter.sv
// Steps: the accepted word is latched and decoded; a rectangle, bitmap pixel or read then
// forms its row base, a rectangle scans its covered pixels and drains its write stage, a
// drawn pixel is written, an on-screen read reads the store; skipped words and other codes
// go straight to the result, which is loaded into the output register once that is free.
// One word at a time: the next enters after that load, while the result may still wait.
// Reset: arst_n clears the controller and the bitmap cursor; the stores are undefined.
module clipped_rect_blitter
	import crb_pkg::*;
#(
	parameter int SCREEN_WIDTH  = CRB_SCREEN_WIDTH,
	parameter int SCREEN_HEIGHT = CRB_SCREEN_HEIGHT
) (
	input logic       clk,
	input logic       arst_n,
	crb_in_if.sink    item,
	crb_out_if.source result
);

	crb_cmd_t  cmd;
	crb_stat_t stat;

	crb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	crb_datapath #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.func           (item.func),
		.pos_x          (item.pos_x),
		.pos_y          (item.pos_y),
		.rect_width     (item.rect_width),
		.rect_height    (item.rect_height),
		.fill_color     (item.fill_color),
		.source_pixel   (item.source_pixel),
		.read_value     (result.read_value),
		.pixels_written (result.pixels_written),
		.status         (result.status)
	);

endmodule

// File: tb/sv/clipped_rect_blitter_tb.sv
module clipped_rect_blitter_tb;
	import crb_pkg::*;

	localparam int SCR_W = CRB_SCREEN_WIDTH;
	localparam int SCR_H = CRB_SCREEN_HEIGHT;
	localparam int SCR_WORDS = SCR_W * SCR_H;

	// Function codes that the block leaves without effect.
	localparam logic [2:0] FUNC_SPARE_A = 3'd6;
	localparam logic [2:0] FUNC_SPARE_B = 3'd7;

	localparam int RANDOM_WORDS = 1100;
	localparam int PHASE_COUNT = 8;
	localparam int HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES = 20;
	localparam int MAX_RANDOM_AREA = 1024;
	localparam int TIMEOUT_TICKS = 100_000_000;

	typedef struct packed {
		logic [2:0]  func;
		logic [11:0] pos_x;
		logic [11:0] pos_y;
		logic [10:0] rect_width;
		logic [10:0] rect_height;
		logic [31:0] fill_color;
		logic [31:0] source_pixel;
	} blit_word_t;

	typedef struct packed {
		logic [31:0] read_value;
		logic [18:0] pixels_written;
		logic [1:0]  status;
	} blit_result_t;

	typedef struct {
		blit_word_t   word;
		bit           typed;
		blit_result_t answer;
	} directed_row_t;

	logic clk;
	logic arst_n;

	crb_in_if  item_if();
	crb_out_if result_if();

	clipped_rect_blitter dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_if),
		.result (result_if)
	);

	// Shadow copy of the screen, the background and the bitmap cursor.
	bit [31:0]   screen_mem [SCR_WORDS];
	bit [31:0]   backdrop_mem [SCR_WORDS];
	bit          backdrop_set [SCR_WORDS];
	logic [11:0] bm_left = '0;
	logic [11:0] bm_top = '0;
	logic [10:0] bm_width = '0;
	logic [10:0] bm_height = '0;
	logic [10:0] bm_col = '0;
	logic [10:0] bm_row = '0;
	bit          bm_open = 1'b0;

	blit_result_t pending_results[$];
	blit_result_t oldest_result;
	directed_row_t dir_rows[$];

	int mismatches = 0;
	int words_accepted = 0;
	int rect_cmds = 0;
	int rect_pixels = 0;
	int bitmap_pixels = 0;
	int screen_reads = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit hold_request = 1'b0;
	bit hold_served = 1'b0;

	// Clock.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs.
	initial begin
		#(TIMEOUT_TICKS);
		$display("Verification failed");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		$display("MISMATCH @%0t: %s", $time, what);
	endtask

	function automatic bit on_screen(input int x, input int y);
		return x >= 0 && x < SCR_W && y >= 0 && y < SCR_H;
	endfunction

	// Clip a rectangle to the screen; an empty result has x1 <= x0 or y1 <= y0.
	function automatic void clip_rect(input blit_word_t w, output int x0, output int x1,
			output int y0, output int y1);
		int x;
		int y;
		x = $signed(w.pos_x);
		y = $signed(w.pos_y);
		x0 = x < 0 ? 0 : x;
		y0 = y < 0 ? 0 : y;
		x1 = x + int'(w.rect_width) > SCR_W ? SCR_W : x + int'(w.rect_width);
		y1 = y + int'(w.rect_height) > SCR_H ? SCR_H : y + int'(w.rect_height);
	endfunction

	function automatic int rect_area(input blit_word_t w);
		int x0, x1, y0, y1;
		clip_rect(w, x0, x1, y0, y1);
		return (x1 > x0 && y1 > y0) ? (x1 - x0) * (y1 - y0) : 0;
	endfunction

	// True when every background word under the clipped rectangle has been saved.
	function automatic bit backdrop_covers(input blit_word_t w);
		int x0, x1, y0, y1, r, c;
		clip_rect(w, x0, x1, y0, y1);
		for (r = y0; r < y1; r++) begin
			for (c = x0; c < x1; c++) begin
				if (!backdrop_set[r * SCR_W + c]) begin
					return 1'b0;
				end
			end
		end
		return 1'b1;
	endfunction

	// Apply one command word to the shadow state and return its result word.
	function automatic blit_result_t blit_predict(input blit_word_t w);
		blit_result_t r;
		int x0, x1, y0, y1, row, col, idx, count, sx, sy;
		r = '0;
		count = 0;
		case (w.func) inside
			FUNC_FILL, FUNC_RESTORE, FUNC_SAVE: begin
				clip_rect(w, x0, x1, y0, y1);
				for (row = y0; row < y1; row++) begin
					for (col = x0; col < x1; col++) begin
						idx = row * SCR_W + col;
						if (w.func == FUNC_FILL) begin
							screen_mem[idx] = w.fill_color;
						end else if (w.func == FUNC_RESTORE) begin
							screen_mem[idx] = backdrop_mem[idx];
						end else begin
							backdrop_mem[idx] = screen_mem[idx];
							backdrop_set[idx] = 1'b1;
						end
						count++;
					end
				end
				r.pixels_written = 19'(count);
			end
			FUNC_OPEN: begin
				bm_left = w.pos_x;
				bm_top = w.pos_y;
				bm_width = w.rect_width;
				bm_height = w.rect_height;
				bm_col = '0;
				bm_row = '0;
				bm_open = 1'b1;
			end
			FUNC_PIXEL: begin
				if (!bm_open || bm_width == 0 || bm_height == 0 || bm_row >= bm_height) begin
					r.status = STATUS_NO_SPACE;
				end else begin
					// File order is bottom row first, so the screen row counts down.
					sx = $signed(bm_left) + int'(bm_col);
					sy = $signed(bm_top) + int'(bm_height) - 1 - int'(bm_row);
					if (on_screen(sx, sy) && w.source_pixel[31:24] > CRB_ALPHA_LIMIT) begin
						screen_mem[sy * SCR_W + sx] = w.source_pixel;
						r.pixels_written = 19'd1;
					end
					bm_col = bm_col + 1'b1;
					if (bm_col >= bm_width) begin
						bm_col = '0;
						bm_row = bm_row + 1'b1;
						if (bm_row >= bm_height) begin
							bm_row = '0;
							bm_open = 1'b0;
						end
					end
				end
			end
			FUNC_READ: begin
				if (on_screen($signed(w.pos_x), $signed(w.pos_y))) begin
					r.read_value = screen_mem[$signed(w.pos_y) * SCR_W + $signed(w.pos_x)];
				end else begin
					r.status = STATUS_OFFSCREEN;
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// Offer one command word, then record its expected result when it is taken.
	task automatic offer_word(input blit_word_t w, input bit typed, input blit_result_t answer);
		blit_result_t predicted;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			item_if.valid = 1'b0;
			@(negedge clk);
		end
		item_if.valid = 1'b1;
		item_if.func = w.func;
		item_if.pos_x = w.pos_x;
		item_if.pos_y = w.pos_y;
		item_if.rect_width = w.rect_width;
		item_if.rect_height = w.rect_height;
		item_if.fill_color = w.fill_color;
		item_if.source_pixel = w.source_pixel;
		@(posedge clk);
		while (!item_if.ready) begin
			@(posedge clk);
		end
		predicted = blit_predict(w);
		pending_results.push_back(typed ? answer : predicted);
		words_accepted++;
		case (w.func) inside
			FUNC_FILL, FUNC_RESTORE, FUNC_SAVE: begin
				rect_cmds++;
				rect_pixels += int'(predicted.pixels_written);
			end
			FUNC_PIXEL: bitmap_pixels++;
			FUNC_READ: screen_reads++;
			default: begin
			end
		endcase
		@(negedge clk);
	endtask

	// Stop sending and wait until every pending result word has come back.
	task automatic drain_results();
		item_if.valid = 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	function automatic directed_row_t dir_row(input logic [2:0] f, input int x, input int y,
			input int wd, input int ht, input logic [31:0] color, input logic [31:0] pix,
			input bit typed, input logic [31:0] value, input int written, input logic [1:0] st);
		directed_row_t d;
		d.word.func = f;
		d.word.pos_x = 12'(x);
		d.word.pos_y = 12'(y);
		d.word.rect_width = 11'(wd);
		d.word.rect_height = 11'(ht);
		d.word.fill_color = color;
		d.word.source_pixel = pix;
		d.typed = typed;
		d.answer.read_value = value;
		d.answer.pixels_written = 19'(written);
		d.answer.status = st;
		return d;
	endfunction

	function automatic blit_word_t random_word(input logic [2:0] f);
		blit_word_t w;
		w.func = f;
		w.pos_x = 12'($urandom);
		w.pos_y = 12'($urandom);
		w.rect_width = 11'($urandom);
		w.rect_height = 11'($urandom);
		w.fill_color = $urandom;
		w.source_pixel = $urandom;
		return w;
	endfunction

	// Mostly small rectangles near the screen; the rest use full-range fields but
	// are kept to a bounded clipped area so the run stays short.
	function automatic blit_word_t random_rect(input logic [2:0] f);
		blit_word_t w;
		int tries;
		w = random_word(f);
		if ($urandom_range(9) < 6) begin
			w.pos_x = 12'(int'($urandom_range(SCR_W + 15)) - 8);
			w.pos_y = 12'(int'($urandom_range(SCR_H + 15)) - 8);
			w.rect_width = 11'($urandom_range(12));
			w.rect_height = 11'($urandom_range(12));
		end else begin
			tries = 0;
			do begin
				w.pos_x = 12'($urandom);
				w.pos_y = 12'($urandom);
				w.rect_width = 11'($urandom);
				w.rect_height = 11'($urandom);
				tries++;
			end while (rect_area(w) > MAX_RANDOM_AREA && tries < 40);
			if (rect_area(w) > MAX_RANDOM_AREA) begin
				w.rect_height = '0;
			end
		end
		// Only restore from background words that have been saved.
		if (f == FUNC_RESTORE && !backdrop_covers(w)) begin
			w.func = FUNC_SAVE;
		end
		return w;
	endfunction

	// Open a bitmap and stream its pixels; some bursts overrun or are abandoned.
	task automatic bitmap_burst();
		blit_word_t w;
		blit_word_t p;
		int n, k;
		w = random_word(FUNC_OPEN);
		if ($urandom_range(5) == 0) begin
			n = $urandom_range(1, 4);
		end else begin
			w.pos_x = 12'(int'($urandom_range(SCR_W + 11)) - 6);
			w.pos_y = 12'(int'($urandom_range(SCR_H + 11)) - 6);
			w.rect_width = 11'($urandom_range(1, 6));
			w.rect_height = 11'($urandom_range(1, 4));
			n = int'(w.rect_width) * int'(w.rect_height);
			if ($urandom_range(7) == 0) begin
				n = $urandom_range(n - 1);
			end else if ($urandom_range(7) == 0) begin
				n = n + 1;
			end
		end
		offer_word(w, 1'b0, '0);
		for (k = 0; k < n; k++) begin
			p = random_word(FUNC_PIXEL);
			case ($urandom_range(3))
				0: p.source_pixel[31:24] = CRB_ALPHA_LIMIT;
				1: p.source_pixel[31:24] = CRB_ALPHA_LIMIT + 8'd1;
				default: begin
				end
			endcase
			offer_word(p, 1'b0, '0);
		end
	endtask

	task automatic random_command();
		blit_word_t w;
		int pick;
		pick = $urandom_range(99);
		if (pick < 30) begin
			bitmap_burst();
		end else if (pick < 60) begin
			case ($urandom_range(2))
				0: w = random_rect(FUNC_FILL);
				1: w = random_rect(FUNC_RESTORE);
				default: w = random_rect(FUNC_SAVE);
			endcase
			offer_word(w, 1'b0, '0);
		end else if (pick < 85) begin
			w = random_word(FUNC_READ);
			if ($urandom_range(3) != 0) begin
				w.pos_x = 12'($urandom_range(SCR_W - 1));
				w.pos_y = 12'($urandom_range(SCR_H - 1));
			end
			offer_word(w, 1'b0, '0);
		end else if (pick < 93) begin
			offer_word(random_word(FUNC_PIXEL), 1'b0, '0);
		end else if (pick < 96) begin
			// A bitmap with no space, followed by a pixel that finds none.
			w = random_word(FUNC_OPEN);
			if ($urandom_range(1) == 0) begin
				w.rect_width = '0;
			end else begin
				w.rect_height = '0;
			end
			offer_word(w, 1'b0, '0);
			offer_word(random_word(FUNC_PIXEL), 1'b0, '0);
		end else begin
			offer_word(random_word($urandom_range(1) == 0 ? FUNC_SPARE_A : FUNC_SPARE_B),
				1'b0, '0);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off on request.
	initial begin
		result_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request && !hold_served) begin
				result_if.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_served = 1'b1;
			end
			result_if.ready = !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
		end
	end

	// Compare each result word with the oldest pending expectation.
	always @(posedge clk) begin
		if (arst_n && result_if.valid && result_if.ready) begin
			if (pending_results.size() == 0) begin
				flag_mismatch("result word with nothing pending");
			end else begin
				oldest_result = pending_results.pop_front();
				if (result_if.read_value !== oldest_result.read_value) begin
					flag_mismatch($sformatf("read_value got %h want %h",
						result_if.read_value, oldest_result.read_value));
				end
				if (result_if.pixels_written !== oldest_result.pixels_written) begin
					flag_mismatch($sformatf("pixels_written got %0d want %0d",
						result_if.pixels_written, oldest_result.pixels_written));
				end
				if (result_if.status !== oldest_result.status) begin
					flag_mismatch($sformatf("status got %0d want %0d",
						result_if.status, oldest_result.status));
				end
			end
		end
	end

	// Stimulus: reset, directed rows, then random phases with different idling.
	initial begin
		int ph;
		int phase_goal;
		arst_n = 1'b0;
		item_if.valid = 1'b0;
		item_if.func = '0;
		item_if.pos_x = '0;
		item_if.pos_y = '0;
		item_if.rect_width = '0;
		item_if.rect_height = '0;
		item_if.fill_color = '0;
		item_if.source_pixel = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Cursor state after reset, off-screen reads and unused codes come before
		// the screen is first filled, so nothing reads an unwritten word.
		dir_rows.push_back(dir_row(FUNC_PIXEL, 0, 0, 0, 0, '0, 32'hFF00_0000,
			1, '0, 0, STATUS_NO_SPACE));
		dir_rows.push_back(dir_row(FUNC_READ, -2048, -2048, 0, 0, '0, '0,
			1, '0, 0, STATUS_OFFSCREEN));
		dir_rows.push_back(dir_row(FUNC_READ, 2047, 2047, 0, 0, '0, '0,
			1, '0, 0, STATUS_OFFSCREEN));
		dir_rows.push_back(dir_row(FUNC_READ, SCR_W, 0, 0, 0, '0, '0,
			1, '0, 0, STATUS_OFFSCREEN));
		dir_rows.push_back(dir_row(FUNC_READ, 0, SCR_H, 0, 0, '0, '0,
			1, '0, 0, STATUS_OFFSCREEN));
		dir_rows.push_back(dir_row(FUNC_SPARE_A, 5, 5, 3, 3, 32'h1234_5678, '0,
			1, '0, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_SPARE_B, -1, -1, 2047, 2047, '1, '1,
			1, '0, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_OPEN, 10, 10, 0, 5, '0, '0,
			1, '0, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_PIXEL, 0, 0, 0, 0, '0, 32'hFFFF_FFFF,
			1, '0, 0, STATUS_NO_SPACE));
		dir_rows.push_back(dir_row(FUNC_FILL, -2048, -2048, 2047, 2047, '1, '0,
			1, '0, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_FILL, 0, 0, 0, 0, '1, '0,
			1, '0, 0, STATUS_OK));
		// Full-screen fill with the largest size.
		dir_rows.push_back(dir_row(FUNC_FILL, 0, 0, 2047, 2047, 32'hA5A5_5A5A, '0,
			1, '0, SCR_WORDS, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_READ, 0, 0, 0, 0, '0, '0,
			1, 32'hA5A5_5A5A, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_READ, SCR_W - 1, SCR_H - 1, 0, 0, '0, '0,
			1, 32'hA5A5_5A5A, 0, STATUS_OK));
		// Clipped save, fill and restore at opposite corners.
		dir_rows.push_back(dir_row(FUNC_SAVE, -5, -5, 10, 10, '0, '0, 0, '0, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_FILL, SCR_W - 5, SCR_H - 5, 2047, 2047, '0, '0,
			0, '0, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_RESTORE, 0, 0, 5, 5, '0, '0, 0, '0, 0, STATUS_OK));
		// A 3x2 bitmap hanging over the top-right corner, alpha at the limit and above.
		dir_rows.push_back(dir_row(FUNC_OPEN, SCR_W - 2, -1, 3, 2, '0, '0,
			1, '0, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_PIXEL, 0, 0, 0, 0, '0, 32'h8011_2233,
			0, '0, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_PIXEL, 0, 0, 0, 0, '0, 32'h8144_5566,
			0, '0, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_PIXEL, 0, 0, 0, 0, '0, 32'hFF77_8899,
			0, '0, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_PIXEL, 0, 0, 0, 0, '0, 32'hFFAA_BBCC,
			0, '0, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_PIXEL, 0, 0, 0, 0, '0, 32'hFFDD_EEFF,
			0, '0, 0, STATUS_OK));
		dir_rows.push_back(dir_row(FUNC_PIXEL, 0, 0, 0, 0, '0, 32'h0000_0000,
			0, '0, 0, STATUS_OK));
		// The bitmap is complete, so one more pixel finds no space.
		dir_rows.push_back(dir_row(FUNC_PIXEL, 0, 0, 0, 0, '0, 32'hFF00_0000,
			1, '0, 0, STATUS_NO_SPACE));
		dir_rows.push_back(dir_row(FUNC_READ, SCR_W - 1, 0, 0, 0, '0, '0,
			0, '0, 0, STATUS_OK));

		foreach (dir_rows[i]) begin
			offer_word(dir_rows[i].word, dir_rows[i].typed, dir_rows[i].answer);
		end
		drain_results();

		// Random phases; each ends with the sender pausing until all results came.
		for (ph = 0; ph < PHASE_COUNT; ph++) begin
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 68;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 68;
				end
				default: begin
					send_idle_pct = 21;
					recv_stall_pct = 21;
				end
			endcase
			if (ph == 0) begin
				hold_request = 1'b1;
			end
			phase_goal = words_accepted + RANDOM_WORDS / PHASE_COUNT;
			while (words_accepted < phase_goal) begin
				random_command();
			end
			drain_results();
		end

		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			flag_mismatch($sformatf("%0d result words never arrived", pending_results.size()));
		end

		$display("Run covered %0d command words: %0d rectangles over %0d screen pixels,",
			words_accepted, rect_cmds, rect_pixels);
		$display("%0d bitmap pixels and %0d reads, under four idling mixes and a long hold-off.",
			bitmap_pixels, screen_reads);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
